>>> sv/fbfl_pkg.sv
// Shared types and constants of the fixed block free list allocator.
package fbfl_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int ADDRESS_BITS = 32;

    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int LINK_W   = IDX_W + 1;
    localparam int POOL_W   = 11;
    localparam int CMP_W    = (LINK_W > POOL_W) ? LINK_W : POOL_W;
    localparam int BYTES_W  = 16;
    localparam int BASE_W   = 32;
    localparam int PROD_W   = IDX_W + BYTES_W;
    localparam int SUM_W    = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
    localparam int ADDR_KEEP = (ADDRESS_BITS < SUM_W) ? ADDRESS_BITS : SUM_W;

    localparam int BINDEX_W = 10;
    localparam int GADDR_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(MAX_BLOCKS);
    localparam logic [POOL_W-1:0] POOL_RESET =
        (MAX_BLOCKS <= 2047) ? POOL_W'(MAX_BLOCKS) : POOL_W'(2047);
    localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = CFG_IDX_W'(2);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_OUTSIDE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } t_ram_wr;

endpackage

>>> sv/fbfl_link_ram.sv
// Link memory: one write port, one read port, registered read data.
module fbfl_link_ram (
    input  logic                          i_clk,
    input  fbfl_pkg::t_ram_wr             i_wr,
    input  logic                          i_re,
    input  logic [fbfl_pkg::IDX_W-1:0]    i_raddr,
    output logic [fbfl_pkg::LINK_W-1:0]   o_rdata
);

    logic [fbfl_pkg::LINK_W-1:0] r_mem [fbfl_pkg::MAX_BLOCKS];
    logic [fbfl_pkg::LINK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fbfl_clear.sv
// Rebuild sweep: writes the descending chain into the link memory.
module fbfl_clear (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output fbfl_pkg::t_ram_wr o_wr
);

    logic                       r_busy;
    logic [fbfl_pkg::IDX_W-1:0] r_cnt;
    logic                       n_busy;
    logic [fbfl_pkg::IDX_W-1:0] n_cnt;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == fbfl_pkg::IDX_W'(fbfl_pkg::MAX_BLOCKS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // entry zero ends the chain, every other entry links one below
    always_comb begin
        o_wr.we   = r_busy;
        o_wr.addr = r_cnt;
        o_wr.data = (r_cnt == '0) ? fbfl_pkg::LINK_END
                                  : fbfl_pkg::LINK_W'(r_cnt) - 1'b1;
    end

    assign o_busy = r_busy;

endmodule

>>> sv/fixed_block_free_list_allocator_top.sv
// Top level of the fixed block free list allocator.
//
// Pool of equal blocks kept as a LIFO free list: a link memory of MAX_BLOCKS
// entries holds each block's successor, a head register the top of the list.
// An allocate request pops the head and returns its index and the address
// pool_base + index * block_bytes; an empty list returns status 1. A free
// request pushes the index back; an index at or beyond the pool size returns
// status 2 and changes nothing. Each request yields one result. The accept
// cycle issues the link read (or the write for a free) and starts the stride
// multiply; the execute state then waits for a free output register, takes
// the registered link read data and loads the output register. A request is
// taken only in the idle state, never before the last one has left execute.
// A finished result waits in the output register and the next request is
// accepted meanwhile. After reset and after every write of pool_blocks a
// rebuild sweep writes the descending chain over all MAX_BLOCKS entries, one
// entry per cycle; no request is accepted during it, configuration writes
// are. Configuration is always ready and must only be written while no
// request is outstanding.
module fixed_block_free_list_allocator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic [fbfl_pkg::BINDEX_W-1:0]    i_block_index,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic [fbfl_pkg::BINDEX_W-1:0]    o_granted_index,
    output logic [fbfl_pkg::GADDR_W-1:0]     o_granted_address
);

    // configuration registers
    logic [fbfl_pkg::BASE_W-1:0]  r_pool_base;
    logic [fbfl_pkg::BYTES_W-1:0] r_block_bytes;
    logic [fbfl_pkg::POOL_W-1:0]  r_pool_blocks;

    // list state
    logic [fbfl_pkg::IDX_W-1:0]   r_head;
    logic                         r_empty;

    // request in flight
    fbfl_pkg::t_state             r_state;
    logic                         r_action;
    fbfl_pkg::t_status            r_res_status;
    logic [fbfl_pkg::IDX_W-1:0]   r_top;
    logic [fbfl_pkg::PROD_W-1:0]  r_prod;

    // output register
    logic                         r_out_valid;
    fbfl_pkg::t_status            r_status;
    logic [fbfl_pkg::BINDEX_W-1:0] r_gidx;
    logic [fbfl_pkg::GADDR_W-1:0]  r_gaddr;

    logic                         cfg_we;
    logic                         pool_wr;
    logic [fbfl_pkg::POOL_W-1:0]  cfg_pool;
    logic [fbfl_pkg::CMP_W-1:0]   cfg_n;
    logic [fbfl_pkg::CMP_W-1:0]   cur_n;
    logic [fbfl_pkg::CMP_W-1:0]   idx_ext;
    logic                         idx_in_pool;
    logic                         accept;
    logic                         out_free;
    logic                         finish;
    logic                         granted;
    logic                         clr_busy;
    fbfl_pkg::t_ram_wr            clr_wr;
    fbfl_pkg::t_ram_wr            free_wr;
    fbfl_pkg::t_ram_wr            ram_wr;
    logic                         ram_re;
    logic [fbfl_pkg::LINK_W-1:0]  ram_rdata;
    logic [fbfl_pkg::SUM_W-1:0]   addr_sum;
    logic [fbfl_pkg::SUM_W-1:0]   addr_mask;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign pool_wr     = cfg_we && (i_cfg_index == fbfl_pkg::CFG_POOL_BLOCKS);
    assign cfg_pool    = i_cfg_data[fbfl_pkg::POOL_W-1:0];

    // clamp the pool size to the memory depth
    assign cfg_n = (fbfl_pkg::CMP_W'(cfg_pool) > fbfl_pkg::CMP_W'(fbfl_pkg::MAX_BLOCKS))
                   ? fbfl_pkg::CMP_W'(fbfl_pkg::MAX_BLOCKS) : fbfl_pkg::CMP_W'(cfg_pool);
    assign cur_n = (fbfl_pkg::CMP_W'(r_pool_blocks) > fbfl_pkg::CMP_W'(fbfl_pkg::MAX_BLOCKS))
                   ? fbfl_pkg::CMP_W'(fbfl_pkg::MAX_BLOCKS)
                   : fbfl_pkg::CMP_W'(r_pool_blocks);

    assign idx_ext     = fbfl_pkg::CMP_W'(i_block_index);
    assign idx_in_pool = idx_ext < cur_n;

    assign o_in_ready = (r_state == fbfl_pkg::S_IDLE) && !clr_busy;
    assign accept     = i_in_valid & o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign finish     = (r_state == fbfl_pkg::S_EXEC) && out_free;
    assign granted    = (r_action == fbfl_pkg::ACT_ALLOC) &&
                        (r_res_status == fbfl_pkg::STATUS_OK);

    // push: link the freed block to the current head
    always_comb begin
        free_wr.we   = accept && (i_action == fbfl_pkg::ACT_FREE) && idx_in_pool;
        free_wr.addr = idx_ext[fbfl_pkg::IDX_W-1:0];
        free_wr.data = r_empty ? fbfl_pkg::LINK_END : fbfl_pkg::LINK_W'(r_head);
    end

    // the sweep owns the write port while it runs; no request is taken then
    assign ram_wr = clr_busy ? clr_wr : free_wr;
    assign ram_re = accept && (i_action == fbfl_pkg::ACT_ALLOC) && !r_empty;

    fbfl_clear u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pool_wr),
        .o_busy  (clr_busy),
        .o_wr    (clr_wr)
    );

    fbfl_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_block_bytes <= fbfl_pkg::BYTES_RESET;
            r_pool_blocks <= fbfl_pkg::POOL_RESET;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                fbfl_pkg::CFG_POOL_BASE: begin
                    r_pool_base <= i_cfg_data[fbfl_pkg::BASE_W-1:0];
                end
                fbfl_pkg::CFG_BLOCK_BYTES: begin
                    r_block_bytes <= i_cfg_data[fbfl_pkg::BYTES_W-1:0];
                end
                fbfl_pkg::CFG_POOL_BLOCKS: begin
                    r_pool_blocks <= cfg_pool;
                end
                default: begin
                end
            endcase
        end
    end

    // head and empty flag: rebuilt on pool size writes, pushed at accept,
    // popped once the successor arrives from the link memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= fbfl_pkg::IDX_W'(fbfl_pkg::CMP_W'(fbfl_pkg::POOL_RESET) - 1'b1);
            r_empty <= (fbfl_pkg::POOL_RESET == '0);
        end else if (pool_wr) begin
            r_empty <= (cfg_n == '0);
            r_head  <= (cfg_n == '0) ? '0
                       : fbfl_pkg::IDX_W'(cfg_n - fbfl_pkg::CMP_W'(1));
        end else if (free_wr.we) begin
            r_head  <= free_wr.addr;
            r_empty <= 1'b0;
        end else if (finish && granted) begin
            if (ram_rdata >= fbfl_pkg::LINK_END) begin
                r_empty <= 1'b1;
                r_head  <= '0;
            end else begin
                r_head <= ram_rdata[fbfl_pkg::IDX_W-1:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbfl_pkg::S_IDLE;
        end else begin
            unique case (r_state)
                fbfl_pkg::S_IDLE: begin
                    if (accept) begin
                        r_state <= fbfl_pkg::S_EXEC;
                    end
                end
                fbfl_pkg::S_EXEC: begin
                    if (out_free) begin
                        r_state <= fbfl_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= fbfl_pkg::S_IDLE;
                end
            endcase
        end
    end

    // capture the request and start the stride multiply
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_top    <= r_head;
            r_prod   <= fbfl_pkg::PROD_W'(r_head) * fbfl_pkg::PROD_W'(r_block_bytes);
            if (i_action == fbfl_pkg::ACT_ALLOC) begin
                r_res_status <= r_empty ? fbfl_pkg::STATUS_EMPTY : fbfl_pkg::STATUS_OK;
            end else begin
                r_res_status <= idx_in_pool ? fbfl_pkg::STATUS_OK
                                            : fbfl_pkg::STATUS_OUTSIDE;
            end
        end
    end

    // address wraps at ADDRESS_BITS before going out on 32 bits
    assign addr_sum  = fbfl_pkg::SUM_W'(r_pool_base) + fbfl_pkg::SUM_W'(r_prod);
    assign addr_mask = (fbfl_pkg::SUM_W'(1) << fbfl_pkg::ADDR_KEEP) - fbfl_pkg::SUM_W'(1);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status <= r_res_status;
            r_gidx   <= granted ? fbfl_pkg::BINDEX_W'(r_top) : '0;
            r_gaddr  <= granted ? fbfl_pkg::GADDR_W'(addr_sum & addr_mask) : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_index   = r_gidx;
    assign o_granted_address = r_gaddr;

endmodule

>>> verif/fixed_block_free_list_allocator_top_tb.sv
// Self-checking testbench for the fixed block free list allocator.
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_top_tb;

    // Generous cycle budget: every rebuild sweep, every request with gaps and
    // result stalls, taken several times over.
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        fbfl_pkg::t_status                status;
        logic [fbfl_pkg::BINDEX_W-1:0]    index;
        logic [fbfl_pkg::GADDR_W-1:0]     address;
    } t_grant;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [fbfl_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [fbfl_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_action = fbfl_pkg::ACT_ALLOC;
    logic [fbfl_pkg::BINDEX_W-1:0]      i_block_index = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [1:0]                         o_status;
    logic [fbfl_pkg::BINDEX_W-1:0]      o_granted_index;
    logic [fbfl_pkg::GADDR_W-1:0]       o_granted_address;

    fixed_block_free_list_allocator_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_block_index    (i_block_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_granted_index  (o_granted_index),
        .o_granted_address(o_granted_address)
    );

    always #5 i_clk = ~i_clk;

    // Pool model: link table, list head, empty flag and register copies.
    logic [fbfl_pkg::LINK_W-1:0]   link_tbl [fbfl_pkg::MAX_BLOCKS];
    logic [fbfl_pkg::LINK_W-1:0]   free_top;
    logic                          list_dry;
    logic [fbfl_pkg::BASE_W-1:0]   m_base;
    logic [fbfl_pkg::BYTES_W-1:0]  m_bytes;
    logic [fbfl_pkg::POOL_W-1:0]   m_blocks;

    t_grant                        awaited_grants [$];   // results owed, oldest first
    logic [fbfl_pkg::BINDEX_W-1:0] owned_blocks [$];     // handed out, not yet freed
    int unsigned                   fail_count = 0;
    int unsigned                   cycle_count = 0;
    bit                            no_idle = 1'b0;       // set for the stretch without idling

    // Each side stalls with a chance of about 22 in a hundred unless idling is off.
    function automatic bit idle_now();
        return no_idle ? 1'b0 : ($urandom_range(99) < 22);
    endfunction

    // Pool sizes above the table depth saturate at the depth.
    function automatic int unsigned usable_blocks();
        return (m_blocks > fbfl_pkg::MAX_BLOCKS) ? fbfl_pkg::MAX_BLOCKS : int'(m_blocks);
    endfunction

    // Rebuild the descending chain; the top of the list is the last block.
    function automatic void rechain_pool();
        for (int i = 0; i < fbfl_pkg::MAX_BLOCKS; i++) begin
            link_tbl[i] = (i == 0) ? fbfl_pkg::LINK_END : fbfl_pkg::LINK_W'(i - 1);
        end
        if (usable_blocks() == 0) begin
            free_top = '0;
            list_dry = 1'b1;
        end else begin
            free_top = fbfl_pkg::LINK_W'(usable_blocks() - 1);
            list_dry = 1'b0;
        end
        owned_blocks.delete();
    endfunction

    // Apply one request to the model and return the result it must produce.
    function automatic t_grant compute_grant(input logic act,
                                             input logic [fbfl_pkg::BINDEX_W-1:0] idx);
        t_grant                      g;
        logic [fbfl_pkg::LINK_W-1:0] succ;
        logic [63:0]                 full_addr;
        g.status  = fbfl_pkg::STATUS_OK;
        g.index   = '0;
        g.address = '0;
        if (act == fbfl_pkg::ACT_ALLOC) begin
            if (list_dry || free_top >= fbfl_pkg::LINK_END) begin
                g.status = fbfl_pkg::STATUS_EMPTY;
            end else begin
                succ      = link_tbl[free_top[fbfl_pkg::IDX_W-1:0]];
                g.index   = free_top[fbfl_pkg::BINDEX_W-1:0];
                full_addr = 64'(m_base) + 64'(free_top) * 64'(m_bytes);
                g.address = full_addr[fbfl_pkg::GADDR_W-1:0];
                if (succ >= fbfl_pkg::LINK_END) begin
                    list_dry = 1'b1;
                    free_top = '0;
                end else begin
                    free_top = succ;
                end
            end
        end else if (int'(idx) >= usable_blocks()) begin
            g.status = fbfl_pkg::STATUS_OUTSIDE;
        end else begin
            link_tbl[idx] = list_dry ? fbfl_pkg::LINK_END : free_top;
            free_top      = fbfl_pkg::LINK_W'(idx);
            list_dry      = 1'b0;
        end
        return g;
    endfunction

    // Count a failure; describe only the first ten.
    task automatic note_failure(input string what, input t_grant want);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch (%s): expected status %0d index %0d addr %h,",
                     what, want.status, want.index, want.address);
            $display("    got status %0d index %0d addr %h",
                     o_status, o_granted_index, o_granted_address);
        end
    endtask

    // Cycle budget: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: compare each accepted result with the oldest expectation,
    // then pick the ready for the next cycle.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_grants.size() == 0) begin
                want.status  = fbfl_pkg::STATUS_OK;
                want.index   = '0;
                want.address = '0;
                note_failure("unexpected result", want);
            end else begin
                want = awaited_grants.pop_front();
                if (o_status !== want.status || o_granted_index !== want.index ||
                    o_granted_address !== want.address) begin
                    note_failure("wrong field", want);
                end
            end
        end
        i_out_ready <= !idle_now();
    end

    // Drop the request valid and hold until every result is in and the last
    // register write has been released; only then is the block idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_grants.size() != 0 || i_cfg_valid) @(posedge i_clk);
    endtask

    // Write one register while idle and mirror it in the model.
    task automatic write_reg(input logic [fbfl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fbfl_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            fbfl_pkg::CFG_POOL_BASE:   m_base  = data[fbfl_pkg::BASE_W-1:0];
            fbfl_pkg::CFG_BLOCK_BYTES: m_bytes = data[fbfl_pkg::BYTES_W-1:0];
            fbfl_pkg::CFG_POOL_BLOCKS: begin
                m_blocks = data[fbfl_pkg::POOL_W-1:0];
                rechain_pool();
            end
            default: ;
        endcase
    endtask

    // Send one request; valid stays high after acceptance so that a request
    // that follows at once is not lowered and raised in one step.
    task automatic send_request(input logic act, input logic [fbfl_pkg::BINDEX_W-1:0] idx);
        t_grant g;
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_block_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        g = compute_grant(act, idx);
        if (act == fbfl_pkg::ACT_ALLOC && g.status == fbfl_pkg::STATUS_OK) begin
            owned_blocks.push_back(g.index);
        end
        awaited_grants.push_back(g);
    endtask

    task automatic take_block();
        send_request(fbfl_pkg::ACT_ALLOC, fbfl_pkg::BINDEX_W'($urandom));
    endtask

    // Reset configuration: 1024 blocks of 64 bytes at address zero.
    task automatic test_reset_pool();
        take_block();                                   // top of list, highest block
        take_block();
        send_request(fbfl_pkg::ACT_FREE, 10'h3FF);      // all-ones index back in
        take_block();                                   // LIFO: same block again
        send_request(fbfl_pkg::ACT_FREE, 10'h000);      // block zero pushed while listed
        take_block();
    endtask

    // Register extremes, saturated and empty pools, single-block pool.
    task automatic test_config_extremes();
        write_reg(fbfl_pkg::CFG_POOL_BASE, 32'hFFFF_FFFF);
        write_reg(fbfl_pkg::CFG_BLOCK_BYTES, 32'h0000_FFFF);
        write_reg(fbfl_pkg::CFG_POOL_BLOCKS, 32'd2047);   // above the depth, saturates
        take_block();                                     // address wraps past 2^32
        send_request(fbfl_pkg::ACT_FREE, 10'd1023);

        write_reg(fbfl_pkg::CFG_POOL_BLOCKS, 32'd0);      // empty pool
        take_block();
        send_request(fbfl_pkg::ACT_FREE, 10'd0);
        send_request(fbfl_pkg::ACT_FREE, 10'd1023);

        write_reg(fbfl_pkg::CFG_POOL_BASE, 32'h0);
        write_reg(fbfl_pkg::CFG_BLOCK_BYTES, 32'd1);
        write_reg(fbfl_pkg::CFG_POOL_BLOCKS, 32'd1);
        take_block();
        take_block();                                     // exhausted
        send_request(fbfl_pkg::ACT_FREE, 10'd1);          // just past the pool
        send_request(fbfl_pkg::ACT_FREE, 10'd0);
        send_request(fbfl_pkg::ACT_FREE, 10'd0);          // double free goes undetected
        take_block();
        take_block();                                     // same block handed out twice
        take_block();

        // Base change keeps the list; only later addresses move.
        write_reg(fbfl_pkg::CFG_POOL_BASE, 32'h8000_0000);
        send_request(fbfl_pkg::ACT_FREE, 10'd0);
        take_block();
    endtask

    // One random phase: fresh registers, then mostly well-formed
    // allocate/free traffic with some noise frees, and a base/stride change
    // half way that keeps the list.
    task automatic run_traffic_phase(input int unsigned blocks, input int unsigned count);
        int unsigned pick;
        int unsigned slot;
        logic [31:0] stride;
        logic [31:0] base;
        for (int i = 0; i < int'(count); i++) begin
            if (i == 0 || i == int'(count) / 2) begin
                pick   = $urandom_range(9);
                stride = (pick == 0) ? 32'h0000_FFFF : (pick == 1) ? 32'd1 :
                         (pick == 2) ? 32'd0 : 32'($urandom_range(1, 65535));
                pick   = $urandom_range(9);
                base   = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'h0 : $urandom;
                write_reg(fbfl_pkg::CFG_POOL_BASE, base);
                write_reg(fbfl_pkg::CFG_BLOCK_BYTES, stride);
                if (i == 0) write_reg(fbfl_pkg::CFG_POOL_BLOCKS, blocks);
            end
            pick = $urandom_range(99);
            if (owned_blocks.size() != 0 && pick < 40) begin
                slot = $urandom_range(owned_blocks.size() - 1);
                send_request(fbfl_pkg::ACT_FREE, owned_blocks[slot]);
                owned_blocks.delete(slot);
            end else if (pick < 88) begin
                take_block();
            end else begin
                // Noise: any index, outside the pool or a double free.
                send_request(fbfl_pkg::ACT_FREE, fbfl_pkg::BINDEX_W'($urandom_range(1023)));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(16, 250);
        run_traffic_phase(1024, 400);
        run_traffic_phase(3, 150);
        run_traffic_phase(1, 80);
        no_idle = 1'b1;                         // both sides run flat out here
        run_traffic_phase(2047, 250);
        no_idle = 1'b0;
        run_traffic_phase(200, 250);
        run_traffic_phase(0, 40);
        run_traffic_phase(7, 200);
    endtask

    initial begin
        m_base   = '0;
        m_bytes  = fbfl_pkg::BYTES_RESET;
        m_blocks = fbfl_pkg::POOL_RESET;
        rechain_pool();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_pool();
        test_config_extremes();
        test_random_traffic();

        // Wait out the last results, then keep the clock running for strays.
        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && awaited_grants.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
